@@ rtl/core/fpbs_pkg.sv @@
// fpbs_pkg: shared widths and the port entry layout for the flow port bandwidth scheduler
// depends on nothing; imported by flow_port_bandwidth_scheduler and its testbench
package fpbs_pkg;

    localparam int ID_W   = 16;
    localparam int BW_W   = 16;
    localparam int TIME_W = 32;

    // one port table entry
    typedef struct packed {
        logic [ID_W-1:0] ident;
        logic [BW_W-1:0] remaining;
    } t_port_ent;

    localparam logic [BW_W-1:0]   BW_MAX   = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

endpackage

@@ rtl/core/flow_port_bandwidth_scheduler.sv @@
// flow_port_bandwidth_scheduler: best-fit flow to port placement with timed release
// depends on fpbs_pkg; holds the port table and the active flow table as memories
//
// usage
//   input word: s_axis_tuser = kind (0 load a port, 1 submit a flow), s_axis_tdata
//   carries item id, bandwidth, start time and send time. a port word fills the
//   next port slot; words beyond PORTS slots are dropped.
//   a flow word yields one output word: flow id, port id and begin time in
//   m_axis_tdata, error flag in m_axis_tuser (set when no port can ever hold it).
// sequence
//   one item is worked at a time. a flow runs an earliest-end scan over the
//   active table, a best-fit scan over the port table and a decision step;
//   every release adds the ST_REL1 and ST_REL2 steps and a fresh pair of scans,
//   and a full active table releases straight after the earliest-end scan. the
//   scans are paced by the single read port of each memory.
// reset
//   synchronous active low; counts and time clear, tables need no clearing pass
//   since only entries below the counts are ever read.
// stall
//   the result sits in an output register; the next word is accepted while it
//   waits, and a later result holds in the decision step until the slot frees.
module flow_port_bandwidth_scheduler
    import fpbs_pkg::*;
#(
    parameter int PORTS      = 16,
    parameter int MAX_ACTIVE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // item_id[15:0], bandwidth[31:16], start_time[63:32], send_time[95:64]
    input  logic [95:0] s_axis_tdata,
    // kind[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // flow_id[15:0], port_id[31:16], begin_time[63:32]
    output logic [63:0] m_axis_tdata,
    // error[0]
    output logic        m_axis_tuser
);

    localparam int PSW = (PORTS > 1) ? $clog2(PORTS) : 1;       // port slot index
    localparam int PCW = $clog2(PORTS + 1);                     // port count
    localparam int AIW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int ACW = $clog2(MAX_ACTIVE + 1);
    localparam int AEW = TIME_W + BW_W + PSW;                   // active entry

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TOP    = 3'd1;
    localparam logic [2:0] ST_ASCAN  = 3'd2;
    localparam logic [2:0] ST_PSCAN  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_REL1   = 3'd5;
    localparam logic [2:0] ST_REL2   = 3'd6;

    // memories
    t_port_ent        port_mem [PORTS];
    logic [AEW-1:0]   act_mem  [MAX_ACTIVE];

    logic [2:0]        r_state;
    logic [PCW-1:0]    r_pcnt;
    logic [ACW-1:0]    r_acnt;
    logic [TIME_W-1:0] r_time;

    // current flow
    logic [ID_W-1:0]   r_fid;
    logic [BW_W-1:0]   r_bw;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_send;

    // scan control
    logic [AIW-1:0]    r_aidx, r_adidx;
    logic [PSW-1:0]    r_pidx, r_pdidx;
    logic              r_dv, r_iss_done;

    // earliest active flow
    logic [AIW-1:0]    r_be;
    logic [TIME_W-1:0] r_bend;
    logic [BW_W-1:0]   r_bneed;
    logic [PSW-1:0]    r_bslot;

    // best-fit port
    logic              r_pfound;
    logic [PSW-1:0]    r_pslot;
    logic [BW_W-1:0]   r_prem;
    logic [ID_W-1:0]   r_pident;

    // output register
    logic              r_ovalid, r_oerr;
    logic [ID_W-1:0]   r_oflow, r_oport;
    logic [TIME_W-1:0] r_obegin;

    // memory ports
    logic [PSW-1:0]    p_raddr, p_waddr;
    logic              p_we;
    t_port_ent         p_wdata, rd_p;
    logic [AIW-1:0]    a_raddr, a_waddr;
    logic              a_we;
    logic [AEW-1:0]    a_wdata, rd_a;

    logic [AIW-1:0]    a_last;
    logic [PSW-1:0]    p_last;
    logic [TIME_W-1:0] rd_end;
    logic              out_free, in_acc, out_load;
    logic [TIME_W-1:0] begin_t, end_t;
    logic [TIME_W:0]   end_sum;
    logic [BW_W:0]     ret_sum;
    logic [BW_W-1:0]   ret_sat;
    logic              fit;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    // decision step emits a word: error word or placement
    assign out_load = (r_state == ST_DECIDE) && out_free &&
                      ((r_acnt == '0 && !r_pfound) ||
                       (r_pfound && (r_acnt == '0 || r_start <= r_bend)));

    assign a_last  = AIW'(r_acnt - ACW'(1));
    assign p_last  = PSW'(r_pcnt - PCW'(1));
    assign rd_end  = rd_a[TIME_W-1:0];
    assign fit     = (rd_p.remaining >= r_bw) && (!r_pfound || rd_p.remaining < r_prem);

    assign begin_t = (r_time > r_start) ? r_time : r_start;
    assign end_sum = {1'b0, begin_t} + {1'b0, r_send};
    assign end_t   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    assign ret_sum = {1'b0, rd_p.remaining} + {1'b0, r_bneed};
    assign ret_sat = ret_sum[BW_W] ? BW_MAX : ret_sum[BW_W-1:0];

    // memory address and write selection
    always_comb begin
        p_raddr = r_pidx;
        a_raddr = r_aidx;
        p_we    = 1'b0;
        p_waddr = r_pslot;
        p_wdata = '{ident: r_pident, remaining: r_prem - r_bw};
        a_we    = 1'b0;
        a_waddr = AIW'(r_acnt);
        a_wdata = {r_pslot, r_bw, end_t};
        unique case (r_state)
            ST_IDLE: begin
                p_waddr = PSW'(r_pcnt);
                p_wdata = '{ident: s_axis_tdata[15:0], remaining: s_axis_tdata[31:16]};
                p_we    = in_acc && !s_axis_tuser && (r_pcnt < PCW'(PORTS));
            end
            ST_REL1: begin
                a_raddr = a_last;
                p_raddr = r_bslot;
            end
            ST_REL2: begin
                p_we    = 1'b1;
                p_waddr = r_bslot;
                p_wdata = '{ident: rd_p.ident, remaining: ret_sat};
                a_we    = 1'b1;
                a_waddr = r_be;
                a_wdata = rd_a;
            end
            ST_DECIDE: begin
                p_we = out_free && r_pfound && (r_acnt == '0 || r_start <= r_bend);
                a_we = p_we;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) port_mem[p_waddr] <= p_wdata;
        rd_p <= port_mem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) act_mem[a_waddr] <= a_wdata;
        rd_a <= act_mem[a_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pcnt     <= '0;
            r_acnt     <= '0;
            r_time     <= '0;
            r_ovalid   <= 1'b0;
            r_dv       <= 1'b0;
            r_iss_done <= 1'b0;
            r_pfound   <= 1'b0;
        end else begin
            r_ovalid <= out_load || (r_ovalid && !m_axis_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (!s_axis_tuser) begin
                            if (r_pcnt < PCW'(PORTS)) r_pcnt <= r_pcnt + PCW'(1);
                        end else begin
                            r_fid   <= s_axis_tdata[15:0];
                            r_bw    <= s_axis_tdata[31:16];
                            r_start <= s_axis_tdata[63:32];
                            r_send  <= s_axis_tdata[95:64];
                            r_state <= ST_TOP;
                        end
                    end
                end
                ST_TOP: begin
                    r_aidx     <= '0;
                    r_pidx     <= '0;
                    r_dv       <= 1'b0;
                    r_iss_done <= 1'b0;
                    r_pfound   <= 1'b0;
                    if (r_acnt != '0)      r_state <= ST_ASCAN;
                    else if (r_pcnt != '0) r_state <= ST_PSCAN;
                    else                   r_state <= ST_DECIDE;
                end
                ST_ASCAN: begin
                    if (!r_iss_done) begin
                        r_aidx     <= r_aidx + AIW'(1);
                        r_dv       <= 1'b1;
                        r_adidx    <= r_aidx;
                        r_iss_done <= (r_aidx == a_last);
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv) begin
                        // strict compare keeps the lowest index on equal ends
                        if (r_adidx == '0 || rd_end < r_bend) begin
                            r_be    <= r_adidx;
                            r_bend  <= rd_end;
                            r_bneed <= rd_a[TIME_W +: BW_W];
                            r_bslot <= rd_a[TIME_W+BW_W +: PSW];
                        end
                        // last read lands after the last issue, so dv already drops
                        if (r_adidx == a_last) begin
                            r_iss_done <= 1'b0;
                            if (r_acnt >= ACW'(MAX_ACTIVE)) r_state <= ST_REL1;
                            else if (r_pcnt != '0)          r_state <= ST_PSCAN;
                            else                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_PSCAN: begin
                    if (!r_iss_done) begin
                        r_pidx     <= r_pidx + PSW'(1);
                        r_dv       <= 1'b1;
                        r_pdidx    <= r_pidx;
                        r_iss_done <= (r_pidx == p_last);
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv) begin
                        if (fit) begin
                            r_pfound <= 1'b1;
                            r_pslot  <= r_pdidx;
                            r_prem   <= rd_p.remaining;
                            r_pident <= rd_p.ident;
                        end
                        if (r_pdidx == p_last) begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (r_acnt == '0 && !r_pfound) begin
                        // nothing to release and no port big enough
                        if (out_free) begin
                            r_oflow  <= r_fid;
                            r_oport  <= '0;
                            r_obegin <= '0;
                            r_oerr   <= 1'b1;
                            r_state  <= ST_IDLE;
                        end
                    end else if (r_pfound && (r_acnt == '0 || r_start <= r_bend)) begin
                        if (out_free) begin
                            r_oflow  <= r_fid;
                            r_oport  <= r_pident;
                            r_obegin <= begin_t;
                            r_oerr   <= 1'b0;
                            r_time   <= begin_t;
                            r_acnt   <= r_acnt + ACW'(1);
                            r_state  <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_REL1;
                    end
                end
                ST_REL1: begin
                    r_state <= ST_REL2;
                end
                ST_REL2: begin
                    // last entry moves into the freed index, bandwidth goes back
                    r_time  <= r_bend;
                    r_acnt  <= r_acnt - ACW'(1);
                    r_state <= ST_TOP;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_obegin, r_oport, r_oflow};
    assign m_axis_tuser  = r_oerr;

    // checks
    a_acnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acnt <= ACW'(MAX_ACTIVE))
        else $error("active count beyond table depth");

    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PCW'(PORTS))
        else $error("port count beyond table depth");

    a_err_no_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oerr) |-> (r_oport == '0 && r_obegin == '0))
        else $error("error word carries port or time");

    a_rel_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REL2) |=> (r_acnt == $past(r_acnt) - ACW'(1)))
        else $error("release did not retire an active flow");

endmodule

@@ tb/sv/tb_flow_port_bandwidth_scheduler.sv @@
// testbench for flow_port_bandwidth_scheduler: best-fit placement of flows on ports
// depends on fpbs_pkg and the scheduler rtl; a local port/active-flow model predicts
// every output word, which a monitor compares field by field
`timescale 1ns / 100ps

module tb_flow_port_bandwidth_scheduler
    import fpbs_pkg::*;
();

    localparam int NUM_PORTS  = 16;
    localparam int NUM_ACTIVE = 64;
    localparam int WATCHDOG   = 200000;
    localparam int TAIL       = 400;

    // item kinds carried on tuser
    localparam bit KIND_PORT = 1'b0;
    localparam bit KIND_FLOW = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   flow_id;
        logic [ID_W-1:0]   port_id;
        logic [TIME_W-1:0] begin_time;
        logic              error;
    } t_placement;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // item_id, bandwidth, start_time, send_time
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // flow_id, port_id, begin_time
    logic        m_axis_tuser;   // error

    flow_port_bandwidth_scheduler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // scheduler model state
    logic [ID_W-1:0]   mdl_port_id  [NUM_PORTS];
    logic [BW_W-1:0]   mdl_port_rem [NUM_PORTS];
    int                mdl_port_cnt;
    logic [TIME_W-1:0] mdl_end      [NUM_ACTIVE];
    logic [BW_W-1:0]   mdl_need     [NUM_ACTIVE];
    int                mdl_slot     [NUM_ACTIVE];
    int                mdl_active;
    logic [TIME_W-1:0] mdl_now;

    t_placement  placements_due[$];
    int          src_idle_pct;
    int          snk_stall_pct;
    int          hold_cycles;
    int          quiet_cycles;
    int          fail_cnt;
    logic [31:0] time_base;

    // earliest end among active flows, lowest index on ties
    function automatic int earliest_flow();
        int best;
        best = 0;
        for (int i = 1; i < mdl_active; i++)
            if (mdl_end[i] < mdl_end[best]) best = i;
        return best;
    endfunction

    function automatic int best_fit_slot(logic [BW_W-1:0] need);
        int best;
        best = NUM_PORTS;
        for (int i = 0; i < mdl_port_cnt; i++)
            if (mdl_port_rem[i] >= need &&
                (best == NUM_PORTS || mdl_port_rem[i] < mdl_port_rem[best]))
                best = i;
        return best;
    endfunction

    // oldest expected placement, removed from the queue
    function automatic t_placement take_due();
        t_placement head;
        head = placements_due[0];
        placements_due.delete(0);
        return head;
    endfunction

    // retire the earliest-ending flow, give its bandwidth back (saturating)
    task automatic release_flow();
        int          e;
        logic [16:0] sum;
        e = earliest_flow();
        mdl_now = mdl_end[e];
        sum = mdl_port_rem[mdl_slot[e]] + mdl_need[e];
        mdl_port_rem[mdl_slot[e]] = sum[16] ? BW_MAX : sum[15:0];
        mdl_active--;
        mdl_end[e]  = mdl_end[mdl_active];
        mdl_need[e] = mdl_need[mdl_active];
        mdl_slot[e] = mdl_slot[mdl_active];
    endtask

    // advance the model by one accepted word, queue the placement it causes
    task automatic schedule_word(bit kind, logic [ID_W-1:0] id, logic [BW_W-1:0] bw,
                                 logic [TIME_W-1:0] st, logic [TIME_W-1:0] sd);
        int          slot;
        logic [32:0] fin;
        t_placement  p;
        if (kind == KIND_PORT) begin
            if (mdl_port_cnt < NUM_PORTS) begin
                mdl_port_id[mdl_port_cnt]  = id;
                mdl_port_rem[mdl_port_cnt] = bw;
                mdl_port_cnt++;
            end
            return;
        end
        forever begin
            if (mdl_active >= NUM_ACTIVE) begin
                release_flow();
                continue;
            end
            slot = best_fit_slot(bw);
            if (mdl_active == 0) begin
                if (slot >= NUM_PORTS) begin
                    p = '{flow_id: id, port_id: '0, begin_time: '0, error: 1'b1};
                    placements_due.push_back(p);
                    return;
                end
                break;
            end
            if (slot < NUM_PORTS && st <= mdl_end[earliest_flow()]) break;
            release_flow();
        end
        if (st > mdl_now) mdl_now = st;
        fin = mdl_now + sd;
        mdl_port_rem[slot] = mdl_port_rem[slot] - bw;
        mdl_end[mdl_active]  = fin[32] ? TIME_MAX : fin[31:0];
        mdl_need[mdl_active] = bw;
        mdl_slot[mdl_active] = slot;
        mdl_active++;
        p = '{flow_id: id, port_id: mdl_port_id[slot], begin_time: mdl_now, error: 1'b0};
        placements_due.push_back(p);
    endtask

    // offer one word, wait for its handshake, then predict
    task automatic send_word(bit kind, logic [ID_W-1:0] id, logic [BW_W-1:0] bw,
                             logic [TIME_W-1:0] st, logic [TIME_W-1:0] sd);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {sd, st, bw, id};
        do @(posedge i_clk); while (!s_axis_tready);
        schedule_word(kind, id, bw, st, sd);
    endtask

    task automatic send_flow(logic [ID_W-1:0] id, logic [BW_W-1:0] bw,
                             logic [TIME_W-1:0] st, logic [TIME_W-1:0] sd);
        send_word(KIND_FLOW, id, bw, st, sd);
    endtask

    // let the input go idle and wait until every placement is back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
    endtask

    // receiver: random stalls, or a long hold-off while hold_cycles runs down
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("flow_port_bandwidth_scheduler verification failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (placements_due.size() == 0) begin
                    $error("unexpected output word %h", m_axis_tdata);
                    fail_cnt++;
                end else begin
                    want = take_due();
                    if (m_axis_tdata[15:0] !== want.flow_id) begin
                        $error("flow_id exp %0d got %0d", want.flow_id, m_axis_tdata[15:0]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[31:16] !== want.port_id) begin
                        $error("port_id exp %0d got %0d", want.port_id, m_axis_tdata[31:16]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[63:32] !== want.begin_time) begin
                        $error("begin_time exp %0d got %0d", want.begin_time,
                               m_axis_tdata[63:32]);
                        fail_cnt++;
                    end
                    if (m_axis_tuser !== want.error) begin
                        $error("error exp %0b got %0b", want.error, m_axis_tuser);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // flow before any port exists: nothing can ever hold it
    task automatic test_no_ports();
        send_flow(16'h0000, 16'h0000, 32'd0, 32'd5);
        send_flow(16'hffff, 16'hffff, 32'd3, 32'd7);
        drain();
    endtask

    // fill the port table with edge ids and capacities, then overflow it
    task automatic test_port_table();
        send_word(KIND_PORT, 16'h0000, 16'h0000, 32'hffffffff, 32'hffffffff);
        send_word(KIND_PORT, 16'hffff, 16'hffff, 32'd0, 32'd0);
        for (int i = 2; i < NUM_PORTS; i++)
            send_word(KIND_PORT, 16'(100 + i), 16'(1000 * i), $urandom, $urandom);
        // table is full, these are dropped
        send_word(KIND_PORT, 16'h5555, 16'h0001, 32'd0, 32'd0);
        send_word(KIND_PORT, 16'haaaa, 16'hfffe, 32'd0, 32'd0);
        drain();
    endtask

    // zero and full needs, best-fit ties, zero send time
    task automatic test_flow_edges();
        send_flow(16'h0001, 16'h0000, 32'd10, 32'd0);
        send_flow(16'h0002, 16'hffff, 32'd10, 32'd20);
        send_flow(16'h0003, 16'hffff, 32'd11, 32'd5);    // waits for the first full one
        send_flow(16'h0004, 16'd2000, 32'd12, 32'd50);
        send_flow(16'h0005, 16'd2000, 32'd12, 32'd50);
        send_flow(16'h0006, 16'd1, 32'd100, 32'd1);      // starts after every end
        drain();
    endtask

    // more flows than the active table holds, all with long lifetimes
    task automatic test_active_full();
        for (int i = 0; i < NUM_ACTIVE + 8; i++)
            send_flow(16'(i), 16'($urandom_range(0, 50)), 32'd200, 32'(1000 + i));
        drain();
    endtask

    task automatic random_flow();
        logic [31:0] st, sd;
        logic [15:0] bw;
        if ($urandom_range(99) < 8) begin
            st = $urandom;
            sd = $urandom;
            bw = 16'($urandom_range(0, 65535));
        end else begin
            time_base = time_base + $urandom_range(0, 12);
            st = time_base + $urandom_range(0, 20);
            sd = ($urandom_range(99) < 5) ? $urandom : $urandom_range(0, 600);
            bw = ($urandom_range(99) < 5) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        end
        if ($urandom_range(99) < 3)
            send_word(KIND_PORT, 16'($urandom), 16'($urandom), $urandom, $urandom);  // ignored
        send_flow(16'($urandom), bw, st, sd);
    endtask

    // random flows under each idling mix
    task automatic test_random_traffic();
        int idle_mix [4][2];
        idle_mix = '{'{0, 0}, '{63, 0}, '{0, 63}, '{19, 19}};
        time_base = 32'd5000;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = idle_mix[ph][0];
            snk_stall_pct = idle_mix[ph][1];
            for (int n = 0; n < 370; n++) random_flow();
            drain();
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    // receiver holds off while flows keep coming, input must back up
    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int n = 0; n < 60; n++) random_flow();
        drain();
    endtask

    // top of the time range: saturated ends and begins near the wrap
    task automatic test_time_extremes();
        send_flow(16'h7001, 16'd10, 32'hfffffff0, 32'hffffffff);
        send_flow(16'h7002, 16'd10, 32'hfffffff8, 32'd100);
        send_flow(16'h7003, 16'd10, 32'hffffffff, 32'h80000000);
        send_flow(16'h7004, 16'hffff, 32'hffffffff, 32'hffffffff);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_cycles   = 0;
        quiet_cycles  = 0;
        fail_cnt      = 0;
        mdl_port_cnt  = 0;
        mdl_active    = 0;
        mdl_now       = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_no_ports();
        test_port_table();
        test_flow_edges();
        test_active_full();
        test_random_traffic();
        test_backpressure();
        test_time_extremes();

        if (fail_cnt == 0 && placements_due.size() == 0)
            $display("flow_port_bandwidth_scheduler verification clean");
        else
            $display("flow_port_bandwidth_scheduler verification failed");
        $finish;
    end

endmodule
